@@ hdl/bgp_message_deframer_defines.svh @@
// Assertion macros for the deframer RTL.
`ifndef BGP_MESSAGE_DEFRAMER_DEFINES_SVH
`define BGP_MESSAGE_DEFRAMER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define BGPD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("deframer invariant violated");

// The consequent must hold in the cycle after the antecedent.
`define BGPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer sequence violated");

`endif

@@ hdl/bgpd_pkg.sv @@
// Types and constants of the message deframer.
package bgpd_pkg;

  localparam int unsigned CountBits = 32;
  localparam int unsigned ExtBits   = (CountBits > 32) ? CountBits : 32;

  localparam logic [4:0] MarkerBytes = 5'd16;
  localparam logic [4:0] LengthLoPos = 5'd17;
  localparam logic [15:0] HeaderBytes = 16'd19;
  localparam logic [4:0] LastHdrPos  = 5'd18;
  localparam logic [7:0] MarkerValue = 8'hFF;

  localparam logic [7:0] TypeOpen      = 8'd1;
  localparam logic [7:0] TypeUpdate    = 8'd2;
  localparam logic [7:0] TypeKeepalive = 8'd4;

  localparam logic [CountBits-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    StExpected   = 3'd0,
    StUnexpected = 3'd1,
    StBadMarker  = 3'd2,
    StBadLength  = 3'd3,
    StEnd        = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PhOpen      = 2'd0,
    PhKeepalive = 2'd1,
    PhRunning   = 2'd2
  } phase_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  message_type;
    logic [15:0] payload_length;
    logic [31:0] message_count;
  } result_t;

endpackage

@@ hdl/bgpd_if.sv @@
// Valid/ready channels for stream bytes and message reports.
interface bgpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface bgpd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  message_type;
  logic [15:0] payload_length;
  logic [31:0] message_count;

  modport source (output valid, output status, output message_type,
                  output payload_length, output message_count, input ready);
  modport sink (input valid, input status, input message_type,
                input payload_length, input message_count, output ready);
endinterface

@@ hdl/bgpd_step.sv @@
// Input register, framing state and the per-byte framing logic.
`include "bgp_message_deframer_defines.svh"

module bgpd_step
  import bgpd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  bgpd_in_if.sink  in_i,
  input  logic     advance_i,
  output logic     emit_o,
  output result_t  result_o
);

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        end_q;

  logic [4:0]           pos_q, pos_d;
  logic [7:0]           len_hi_q, len_hi_d;
  logic [15:0]          left_q, left_d;
  logic                 marker_good_q, marker_good_d;
  logic [7:0]           held_type_q, held_type_d;
  logic [15:0]          held_len_q, held_len_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 halted_q, halted_d;
  phase_e               phase_q, phase_d;

  logic        fire;
  logic        complete;
  logic        type_ok;
  logic        in_payload;
  logic [7:0]  done_type;
  logic [15:0] done_len;
  logic [15:0] left_dec;
  logic [15:0] left_net;
  logic [15:0] total_len;
  logic [ExtBits-1:0] count_ext;
  logic [CountBits-1:0] count_inc;
  logic [ExtBits-1:0]   inc_ext;

  assign fire       = in_valid_q && advance_i;
  assign in_i.ready = advance_i || !in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.in_byte;
      end_q  <= in_i.stream_end;
    end
  end

  assign left_dec  = left_q - 16'd1;
  assign total_len = {len_hi_q, byte_q};
  assign left_net  = left_q - HeaderBytes;
  assign count_ext = ExtBits'(count_q);
  assign count_inc = (count_q != CountMax) ? count_q + CountBits'(1) : count_q;
  assign inc_ext   = ExtBits'(count_inc);

  // A message completes either on its last payload byte or on its type byte.
  assign in_payload = (pos_q == 5'd0) && (left_q != 16'd0);
  assign done_type  = in_payload ? held_type_q : byte_q;
  assign done_len   = in_payload ? held_len_q : left_net;

  // Framing datapath: one stream byte per fire.
  always_comb begin
    pos_d         = pos_q;
    len_hi_d      = len_hi_q;
    left_d        = left_q;
    marker_good_d = marker_good_q;
    held_type_d   = held_type_q;
    held_len_d    = held_len_q;
    halted_d      = halted_q;
    count_d       = count_q;
    complete      = 1'b0;
    emit_o        = 1'b0;
    result_o.status         = StEnd;
    result_o.message_type   = 8'd0;
    result_o.payload_length = 16'd0;
    result_o.message_count  = count_ext[31:0];

    if (fire) begin
      if (end_q) begin
        emit_o        = 1'b1;
        pos_d         = '0;
        len_hi_d      = '0;
        left_d        = '0;
        marker_good_d = 1'b1;
        held_type_d   = '0;
        held_len_d    = '0;
        halted_d      = 1'b0;
        count_d       = '0;
      end else if (halted_q) begin
        emit_o = 1'b0;
      end else if (in_payload) begin
        left_d   = left_dec;
        complete = (left_dec == 16'd0);
      end else if (pos_q < MarkerBytes) begin
        if (byte_q != MarkerValue) begin
          marker_good_d = 1'b0;
        end
        pos_d = pos_q + 5'd1;
      end else if (pos_q == MarkerBytes) begin
        len_hi_d = byte_q;
        pos_d    = pos_q + 5'd1;
      end else if (pos_q == LengthLoPos) begin
        left_d = total_len;
        pos_d  = pos_q + 5'd1;
      end else begin
        // Type byte: the header is complete.
        held_type_d = byte_q;
        pos_d       = '0;
        if (!marker_good_q) begin
          halted_d        = 1'b1;
          left_d          = '0;
          emit_o          = 1'b1;
          result_o.status = StBadMarker;
        end else if (left_q < HeaderBytes) begin
          halted_d        = 1'b1;
          left_d          = '0;
          emit_o          = 1'b1;
          result_o.status = StBadLength;
        end else begin
          left_d     = left_net;
          held_len_d = left_net;
          complete   = (left_net == 16'd0);
        end
      end

      if (complete) begin
        // The report carries the count that includes this message.
        count_d                 = count_inc;
        emit_o                  = 1'b1;
        result_o.status         = type_ok ? StExpected : StUnexpected;
        result_o.message_type   = done_type;
        result_o.payload_length = done_len;
        result_o.message_count  = inc_ext[31:0];
      end
    end
  end

  // Session order: next phase.
  always_comb begin
    phase_d = phase_q;
    if (fire && end_q) begin
      phase_d = PhOpen;
    end else if (complete) begin
      unique case (phase_q)
        PhOpen:      phase_d = PhKeepalive;
        PhKeepalive: phase_d = PhRunning;
        default:     phase_d = PhRunning;
      endcase
    end
  end

  // Session order: whether the completed type fits the phase.
  always_comb begin
    unique case (phase_q)
      PhOpen:      type_ok = (done_type == TypeOpen);
      PhKeepalive: type_ok = (done_type == TypeKeepalive);
      default:     type_ok = (done_type == TypeKeepalive) || (done_type == TypeUpdate);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      len_hi_q      <= '0;
      left_q        <= '0;
      marker_good_q <= 1'b1;
      held_type_q   <= '0;
      held_len_q    <= '0;
      count_q       <= '0;
      halted_q      <= 1'b0;
      phase_q       <= PhOpen;
    end else begin
      pos_q         <= pos_d;
      len_hi_q      <= len_hi_d;
      left_q        <= left_d;
      marker_good_q <= marker_good_d;
      held_type_q   <= held_type_d;
      held_len_q    <= held_len_d;
      count_q       <= count_d;
      halted_q      <= halted_d;
      phase_q       <= phase_d;
    end
  end

  `BGPD_ASSERT_ALWAYS(a_pos_range, clk_i, rst_ni, pos_q <= LastHdrPos)
  `BGPD_ASSERT_ALWAYS(a_halted_idle, clk_i, rst_ni, !halted_q || (pos_q == 5'd0 && left_q == 16'd0))
  `BGPD_ASSERT_ALWAYS(a_phase_count, clk_i, rst_ni, phase_q == PhOpen || count_q != '0)
  `BGPD_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, fire && end_q, count_q == '0 && phase_q == PhOpen && !halted_q)

endmodule

@@ hdl/bgpd_out_reg.sv @@
// Result register that decouples the framing stage from the report consumer.
module bgpd_out_reg
  import bgpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       emit_i,
  input  result_t    result_i,
  output logic       advance_o,
  bgpd_out_if.source out_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // The framing stage may move whenever this register is empty or drains now.
  assign advance_o = !valid_q || out_o.ready;
  assign valid_d   = advance_o ? emit_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && emit_i) begin
      data_q <= result_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.status         = data_q.status;
  assign out_o.message_type   = data_q.message_type;
  assign out_o.payload_length = data_q.payload_length;
  assign out_o.message_count  = data_q.message_count;

endmodule

@@ hdl/bgp_message_deframer.sv @@
// Top level of the message deframer: byte stream in, message reports out.
//
//   Channel  Dir  Beat carries                                         Flow
//   in_i     in   in_byte, stream_end                                  valid/ready
//   out_o    out  status, message_type, payload_length, message_count  valid/ready
//
// One byte is taken every cycle while reports drain; a byte passes the input
// register, and its report then passes the result register.
// Reset clears the framing state, the session phase and the message count.
// A stalled report holds the framing stage; the input register still takes a
// byte while it is empty, so no bubble forms when the consumer resumes.
module bgp_message_deframer
  import bgpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bgpd_in_if.sink    in_i,
  bgpd_out_if.source out_o
);

  logic    advance;
  logic    emit;
  result_t result;

  bgpd_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .emit_o    (emit),
    .result_o  (result)
  );

  bgpd_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .emit_i    (emit),
    .result_i  (result),
    .advance_o (advance),
    .out_o     (out_o)
  );

endmodule
